>>> rtl/wsd_pkg.sv
package wsd_pkg;

  // Parse phases of the frame header and payload
  typedef enum logic [2:0] {
    PH_HDR0  = 3'd0,
    PH_HDR1  = 3'd1,
    PH_EXT16 = 3'd2,
    PH_EXT64 = 3'd3,
    PH_KEY   = 3'd4,
    PH_DATA  = 3'd5
  } phase_e;

  localparam int unsigned QueueDepth = 2;

  localparam logic [6:0] LenCode16  = 7'd126;
  localparam logic [6:0] LenCode64  = 7'd127;
  localparam logic [2:0] Ext16Bytes = 3'd2;
  localparam logic [2:0] Ext64Bytes = 3'd0;  // eight bytes, count wraps to zero
  localparam logic [2:0] KeyBytes   = 3'd4;

  // One payload result as it travels from parser to output queue
  typedef struct packed {
    logic [7:0] payload_byte;
    logic       last_of_payload;
    logic [3:0] frame_opcode;
    logic       final_fragment;
  } result_t;

endpackage

>>> rtl/wsd_if.sv
interface wsd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink   (input valid, input in_byte, output ready);
endinterface

interface wsd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] payload_byte;
  logic       last_of_payload;
  logic [3:0] frame_opcode;
  logic       final_fragment;

  modport source (output valid, output payload_byte, output last_of_payload,
                  output frame_opcode, output final_fragment, input ready);
  modport sink   (input valid, input payload_byte, input last_of_payload,
                  input frame_opcode, input final_fragment, output ready);
endinterface

>>> rtl/websocket_frame_deframer_core.sv
// WebSocket (RFC 6455) frame deframer. Takes the raw frame stream one byte per
// transfer on in_i and returns one transfer on out_o for every payload byte,
// unmasked with the frame's key when the mask bit is set, tagged with the
// frame's opcode and FIN bit and flagged on the last byte of the frame. Header,
// extended-length and key bytes give no output, nor does a zero-length frame.
// Frames may follow one another with no gap. Throughput is one byte per clock:
// the parser takes a byte every cycle while the output queue (QueueDepth
// entries, default 2) has room, and each payload byte is registered in the
// queue and reaches out_o once the results ahead of it have been taken. Ready
// on in_i drops only when the queue is full, so a stalled consumer holds the
// parser back after QueueDepth results. Reserved bits are ignored and opcodes
// are passed through unchecked; all 64 bits of a 64-bit length are honoured.
module websocket_frame_deframer_core #(
  parameter int unsigned QueueDepth = wsd_pkg::QueueDepth
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  wsd_in_if.sink    in_i,
  wsd_out_if.source out_o
);

  logic             push;
  logic             q_ready;
  wsd_pkg::result_t push_data;
  wsd_pkg::result_t pop_data;

  assign in_i.ready = q_ready;

  // Parser: classifies each byte and unmasks payload bytes
  wsd_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_byte_i   (in_i.in_byte),
    .in_ready_i  (q_ready),
    .push_o      (push),
    .push_data_o (push_data)
  );

  // Output queue: decouples parser from the consumer
  wsd_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ready_o     (q_ready),
    .push_i      (push),
    .push_data_i (push_data),
    .valid_o     (out_o.valid),
    .pop_ready_i (out_o.ready),
    .pop_data_o  (pop_data)
  );

  assign out_o.payload_byte    = pop_data.payload_byte;
  assign out_o.last_of_payload = pop_data.last_of_payload;
  assign out_o.frame_opcode    = pop_data.frame_opcode;
  assign out_o.final_fragment  = pop_data.final_fragment;

endmodule

>>> rtl/wsd_front.sv
module wsd_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic [7:0]        in_byte_i,
  input  logic              in_ready_i,
  output logic              push_o,
  output wsd_pkg::result_t  push_data_o
);

  wsd_pkg::phase_e phase_q, phase_d;
  logic [2:0]  hdr_cnt_q, hdr_cnt_d;
  logic [3:0]  opcode_q, opcode_d;
  logic        fin_q, fin_d;
  logic        masked_q, masked_d;
  logic [63:0] remaining_q, remaining_d;
  logic [31:0] key_q, key_d;
  logic [1:0]  key_pos_q, key_pos_d;

  logic        fire;
  logic [6:0]  len_code;
  logic [2:0]  hdr_cnt_inc;
  logic [2:0]  ext_need;
  logic        ext_done;
  logic        key_done;
  logic        data_last;
  logic [7:0]  key_byte;
  wsd_pkg::phase_e after_len;

  assign fire        = in_valid_i && in_ready_i;
  assign len_code    = in_byte_i[6:0];
  assign hdr_cnt_inc = hdr_cnt_q + 3'd1;
  assign ext_need    = (phase_q == wsd_pkg::PH_EXT16) ? wsd_pkg::Ext16Bytes
                                                      : wsd_pkg::Ext64Bytes;
  assign ext_done    = (hdr_cnt_inc == ext_need);
  assign key_done    = (hdr_cnt_inc == wsd_pkg::KeyBytes);
  assign data_last   = (remaining_q == 64'd1);

  // key byte 0 sits in the top byte of the key
  always_comb begin
    case (key_pos_q)
      2'd0:    key_byte = key_q[31:24];
      2'd1:    key_byte = key_q[23:16];
      2'd2:    key_byte = key_q[15:8];
      default: key_byte = key_q[7:0];
    endcase
  end

  // where to go once the length is known; remaining_d holds the length
  always_comb begin
    if (masked_d) begin
      after_len = wsd_pkg::PH_KEY;
    end else if (remaining_d != 64'd0) begin
      after_len = wsd_pkg::PH_DATA;
    end else begin
      after_len = wsd_pkg::PH_HDR0;
    end
  end

  // next phase
  always_comb begin
    phase_d = phase_q;
    if (fire) begin
      case (phase_q)
        wsd_pkg::PH_HDR0: phase_d = wsd_pkg::PH_HDR1;
        wsd_pkg::PH_HDR1: begin
          if (len_code == wsd_pkg::LenCode16) begin
            phase_d = wsd_pkg::PH_EXT16;
          end else if (len_code == wsd_pkg::LenCode64) begin
            phase_d = wsd_pkg::PH_EXT64;
          end else begin
            phase_d = after_len;
          end
        end
        wsd_pkg::PH_EXT16, wsd_pkg::PH_EXT64: begin
          if (ext_done) begin
            phase_d = after_len;
          end
        end
        wsd_pkg::PH_KEY: begin
          if (key_done) begin
            phase_d = (remaining_q != 64'd0) ? wsd_pkg::PH_DATA : wsd_pkg::PH_HDR0;
          end
        end
        wsd_pkg::PH_DATA: begin
          if (data_last) begin
            phase_d = wsd_pkg::PH_HDR0;
          end
        end
        default: phase_d = wsd_pkg::PH_HDR0;
      endcase
    end
  end

  // datapath and result
  always_comb begin
    hdr_cnt_d   = hdr_cnt_q;
    opcode_d    = opcode_q;
    fin_d       = fin_q;
    masked_d    = masked_q;
    remaining_d = remaining_q;
    key_d       = key_q;
    key_pos_d   = key_pos_q;
    push_o      = 1'b0;
    push_data_o.payload_byte    = masked_q ? (in_byte_i ^ key_byte) : in_byte_i;
    push_data_o.last_of_payload = data_last;
    push_data_o.frame_opcode    = opcode_q;
    push_data_o.final_fragment  = fin_q;
    if (fire) begin
      case (phase_q)
        wsd_pkg::PH_HDR0: begin
          opcode_d = in_byte_i[3:0];
          fin_d    = in_byte_i[7];
        end
        wsd_pkg::PH_HDR1: begin
          masked_d  = in_byte_i[7];
          hdr_cnt_d = 3'd0;
          if ((len_code == wsd_pkg::LenCode16) || (len_code == wsd_pkg::LenCode64)) begin
            remaining_d = 64'd0;
          end else begin
            remaining_d = {57'd0, len_code};
            key_pos_d   = 2'd0;
          end
        end
        wsd_pkg::PH_EXT16, wsd_pkg::PH_EXT64: begin
          remaining_d = {remaining_q[55:0], in_byte_i};
          hdr_cnt_d   = hdr_cnt_inc;
          if (ext_done) begin
            hdr_cnt_d = 3'd0;
            key_pos_d = 2'd0;
          end
        end
        wsd_pkg::PH_KEY: begin
          key_d     = {key_q[23:0], in_byte_i};
          hdr_cnt_d = hdr_cnt_inc;
          if (key_done) begin
            hdr_cnt_d = 3'd0;
            key_pos_d = 2'd0;
          end
        end
        wsd_pkg::PH_DATA: begin
          push_o      = 1'b1;
          remaining_d = remaining_q - 64'd1;
          key_pos_d   = data_last ? 2'd0 : key_pos_q + 2'd1;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= wsd_pkg::PH_HDR0;
      hdr_cnt_q   <= 3'd0;
      opcode_q    <= 4'd0;
      fin_q       <= 1'b0;
      masked_q    <= 1'b0;
      remaining_q <= 64'd0;
      key_q       <= 32'd0;
      key_pos_q   <= 2'd0;
    end else begin
      phase_q     <= phase_d;
      hdr_cnt_q   <= hdr_cnt_d;
      opcode_q    <= opcode_d;
      fin_q       <= fin_d;
      masked_q    <= masked_d;
      remaining_q <= remaining_d;
      key_q       <= key_d;
      key_pos_q   <= key_pos_d;
    end
  end

  a_data_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == wsd_pkg::PH_DATA) |-> (remaining_q != 64'd0))
    else $error("data phase with no payload left");

  a_key_needs_mask: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == wsd_pkg::PH_KEY) |-> masked_q)
    else $error("key phase in unmasked frame");

  a_last_returns: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_o && push_data_o.last_of_payload) |=> (phase_q == wsd_pkg::PH_HDR0))
    else $error("parser did not return to header after last byte");

endmodule

>>> rtl/wsd_queue.sv
module wsd_queue #(
  parameter int unsigned Depth = wsd_pkg::QueueDepth
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  output logic              ready_o,
  input  logic              push_i,
  input  wsd_pkg::result_t  push_data_i,
  output logic              valid_o,
  input  logic              pop_ready_i,
  output wsd_pkg::result_t  pop_data_o
);

  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);

  wsd_pkg::result_t mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic pop;

  assign ready_o    = (count_q < CntW'(Depth));
  assign valid_o    = (count_q != '0);
  assign pop        = valid_o && pop_ready_i;
  assign pop_data_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> (count_q < CntW'(Depth)) || pop)
    else $error("write into full queue");

  a_count_up: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && !pop) |=> (count_q == $past(count_q) + 1'b1))
    else $error("queue count lost a write");

  a_count_down: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && !push_i) |=> (count_q == $past(count_q) - 1'b1))
    else $error("queue count lost a read");

endmodule
